@@ rtl/core/tps_pkg.sv @@
// Shared types, register codes and helper functions of the trapezoid profile step.
package tps_pkg;

    // Register indexes of the configuration port
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_PLAN_STOPPED = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_TIME   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_RATE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COAST_TIME   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DECEL_TIME   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DECEL_RATE   = 3'd5;

    // Pipeline stages, in order
    localparam int unsigned PIPE_STAGES = 7;
    localparam int unsigned ST_A = 0;
    localparam int unsigned ST_B = 1;
    localparam int unsigned ST_C = 2;
    localparam int unsigned ST_D = 3;
    localparam int unsigned ST_E = 4;
    localparam int unsigned ST_F = 5;
    localparam int unsigned ST_G = 6;

    // Wide position accumulator: input plus three terms of at most 2^47 each
    localparam int unsigned ACC_W = 52;
    typedef logic signed [ACC_W-1:0] acc_t;

    // Configuration register set
    typedef struct packed {
        logic               plan_stopped;
        logic [31:0]        accel_time;
        logic signed [31:0] accel_rate;
        logic [31:0]        coast_time;
        logic [31:0]        decel_time;
        logic signed [31:0] decel_rate;
    } tps_cfg_t;

    // Clamp a wide signed value to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input acc_t x);
        logic [ACC_W-32:0] upper;
        upper = x[ACC_W-1:31];
        if (upper == '0 || upper == '1)
        begin
            return x[31:0];
        end
        else if (x[ACC_W-1])
        begin
            return 32'sh8000_0000;
        end
        else
        begin
            return 32'sh7fff_ffff;
        end
    endfunction

    // Smaller of two unsigned times
    function automatic logic [31:0] min_u32(input logic [31:0] a, input logic [31:0] b);
        return (a <= b) ? a : b;
    endfunction

endpackage

@@ rtl/core/tps_flow_ctrl.sv @@
// Valid and ready chain of the pipeline: stages advance independently and bubbles collapse.
module tps_flow_ctrl #(
    parameter int unsigned STAGES = tps_pkg::PIPE_STAGES
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [STAGES-1:0] load
);

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES:0]   stage_ready;

    // A stage takes new content when empty or when its content moves on
    assign stage_ready[STAGES] = out_ready;

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        assign stage_ready[i] = !valid_reg[i] || stage_ready[i+1];
        if (i == 0)
        begin : g_first
            assign valid_next[i] = stage_ready[i] ? in_valid : valid_reg[i];
        end
        else
        begin : g_rest
            assign valid_next[i] = stage_ready[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    // Hold the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign load      = stage_ready[STAGES-1:0];
    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[STAGES-1];

endmodule

@@ rtl/core/tps_datapath.sv @@
// Seven-stage datapath: phase time split, ramp and coast integration, saturation.
module tps_datapath (
    input  logic                               clk,
    input  tps_pkg::tps_cfg_t                  cfg,
    input  logic [tps_pkg::PIPE_STAGES-1:0]    load,
    input  logic [31:0]                        step_time,
    input  logic signed [31:0]                 position_in,
    input  logic signed [31:0]                 speed_in,
    output logic signed [31:0]                 position_out,
    output logic signed [31:0]                 speed_out,
    output logic                               plan_done
);

    // Stage A: acceleration time
    logic [31:0]        a_left;
    logic [31:0]        a_u1_next, a_t1_next;
    logic [31:0]        a_u1_reg, a_t1_reg;
    logic signed [31:0] a_pos_reg, a_v_reg;
    logic               a_stop_reg;

    // Stage B: acceleration product, coast time
    logic signed [64:0] b_prod;
    logic [31:0]        b_u2_next, b_t2_next;
    logic signed [63:0] b_p1_reg;
    logic [31:0]        b_u1_reg, b_u2_reg, b_t2_reg;
    logic signed [31:0] b_pos_reg, b_v_reg;
    logic               b_stop_reg;

    // Stage C: velocity after acceleration, deceleration time
    logic signed [46:0] c_half;
    logic signed [47:0] c_dv;
    logic signed [31:0] c_mean1_next, c_v1_next;
    logic [31:0]        c_u3_next;
    logic               c_done_next;
    logic signed [31:0] c_mean1_reg, c_v1_reg, c_pos_reg;
    logic [31:0]        c_u1_reg, c_u2_reg, c_u3_reg;
    logic               c_done_reg;

    // Stage D: acceleration distance, coast distance, deceleration product
    logic signed [64:0] d_q1_prod, d_c2_prod, d_p3_prod;
    logic signed [63:0] d_q1_reg, d_c2_reg, d_p3_reg;
    logic signed [31:0] d_v1_reg, d_pos_reg;
    logic [31:0]        d_u3_reg;
    logic               d_done_reg;

    // Stage E: first position sum, velocity after deceleration
    logic signed [47:0] e_q1s, e_dv;
    logic signed [46:0] e_half;
    tps_pkg::acc_t      e_posa_next;
    logic signed [31:0] e_mean3_next, e_v3_next;
    tps_pkg::acc_t      e_posa_reg;
    logic signed [47:0] e_c2s_reg;
    logic signed [31:0] e_mean3_reg, e_v3_reg;
    logic [31:0]        e_u3_reg;
    logic               e_done_reg;

    // Stage F: deceleration distance, second position sum
    logic signed [64:0] f_q3_prod;
    tps_pkg::acc_t      f_posb_next;
    logic signed [63:0] f_q3_reg;
    tps_pkg::acc_t      f_posb_reg;
    logic signed [31:0] f_v3_reg;
    logic               f_done_reg;

    // Stage G: final position, saturated
    logic signed [47:0] g_q3s;
    logic signed [31:0] g_pos_next;
    logic signed [31:0] g_pos_reg, g_v_reg;
    logic               g_done_reg;

    // A stopped plan spends no time, so every phase leaves the values untouched
    assign a_left    = cfg.plan_stopped ? '0 : step_time;
    assign a_u1_next = tps_pkg::min_u32(a_left, cfg.accel_time);
    assign a_t1_next = a_left - a_u1_next;

    always_ff @(posedge clk)
    begin
        if (load[tps_pkg::ST_A])
        begin
            a_u1_reg   <= a_u1_next;
            a_t1_reg   <= a_t1_next;
            a_pos_reg  <= position_in;
            a_v_reg    <= speed_in;
            a_stop_reg <= cfg.plan_stopped;
        end
    end

    // Multiply acceleration rate by its used time; clip the coast phase
    assign b_prod    = cfg.accel_rate * $signed({1'b0, a_u1_reg});
    assign b_u2_next = tps_pkg::min_u32(a_t1_reg, cfg.coast_time);
    assign b_t2_next = a_t1_reg - b_u2_next;

    always_ff @(posedge clk)
    begin
        if (load[tps_pkg::ST_B])
        begin
            b_p1_reg   <= b_prod[63:0];
            b_u1_reg   <= a_u1_reg;
            b_u2_reg   <= b_u2_next;
            b_t2_reg   <= b_t2_next;
            b_pos_reg  <= a_pos_reg;
            b_v_reg    <= a_v_reg;
            b_stop_reg <= a_stop_reg;
        end
    end

    // Mean and end velocity of the acceleration phase; clip deceleration
    assign c_half       = b_p1_reg[63:17];
    assign c_dv         = b_p1_reg[63:16];
    assign c_mean1_next = tps_pkg::sat32(tps_pkg::acc_t'(b_v_reg) + tps_pkg::acc_t'(c_half));
    assign c_v1_next    = tps_pkg::sat32(tps_pkg::acc_t'(b_v_reg) + tps_pkg::acc_t'(c_dv));
    assign c_u3_next    = tps_pkg::min_u32(b_t2_reg, cfg.decel_time);
    assign c_done_next  = b_stop_reg || (b_t2_reg > cfg.decel_time);

    always_ff @(posedge clk)
    begin
        if (load[tps_pkg::ST_C])
        begin
            c_mean1_reg <= c_mean1_next;
            c_v1_reg    <= c_v1_next;
            c_pos_reg   <= b_pos_reg;
            c_u1_reg    <= b_u1_reg;
            c_u2_reg    <= b_u2_reg;
            c_u3_reg    <= c_u3_next;
            c_done_reg  <= c_done_next;
        end
    end

    // Three independent products
    assign d_q1_prod = c_mean1_reg * $signed({1'b0, c_u1_reg});
    assign d_c2_prod = c_v1_reg * $signed({1'b0, c_u2_reg});
    assign d_p3_prod = cfg.decel_rate * $signed({1'b0, c_u3_reg});

    always_ff @(posedge clk)
    begin
        if (load[tps_pkg::ST_D])
        begin
            d_q1_reg   <= d_q1_prod[63:0];
            d_c2_reg   <= d_c2_prod[63:0];
            d_p3_reg   <= d_p3_prod[63:0];
            d_v1_reg   <= c_v1_reg;
            d_pos_reg  <= c_pos_reg;
            d_u3_reg   <= c_u3_reg;
            d_done_reg <= c_done_reg;
        end
    end

    // Add acceleration distance; mean and end velocity of deceleration
    assign e_q1s        = d_q1_reg[63:16];
    assign e_half       = d_p3_reg[63:17];
    assign e_dv         = d_p3_reg[63:16];
    assign e_posa_next  = tps_pkg::acc_t'(d_pos_reg) + tps_pkg::acc_t'(e_q1s);
    assign e_mean3_next = tps_pkg::sat32(tps_pkg::acc_t'(d_v1_reg) + tps_pkg::acc_t'(e_half));
    assign e_v3_next    = tps_pkg::sat32(tps_pkg::acc_t'(d_v1_reg) + tps_pkg::acc_t'(e_dv));

    always_ff @(posedge clk)
    begin
        if (load[tps_pkg::ST_E])
        begin
            e_posa_reg  <= e_posa_next;
            e_c2s_reg   <= d_c2_reg[63:16];
            e_mean3_reg <= e_mean3_next;
            e_v3_reg    <= e_v3_next;
            e_u3_reg    <= d_u3_reg;
            e_done_reg  <= d_done_reg;
        end
    end

    // Deceleration distance; add coast distance
    assign f_q3_prod   = e_mean3_reg * $signed({1'b0, e_u3_reg});
    assign f_posb_next = e_posa_reg + tps_pkg::acc_t'(e_c2s_reg);

    always_ff @(posedge clk)
    begin
        if (load[tps_pkg::ST_F])
        begin
            f_q3_reg   <= f_q3_prod[63:0];
            f_posb_reg <= f_posb_next;
            f_v3_reg   <= e_v3_reg;
            f_done_reg <= e_done_reg;
        end
    end

    // Add deceleration distance and clamp the position once
    assign g_q3s      = f_q3_reg[63:16];
    assign g_pos_next = tps_pkg::sat32(f_posb_reg + tps_pkg::acc_t'(g_q3s));

    always_ff @(posedge clk)
    begin
        if (load[tps_pkg::ST_G])
        begin
            g_pos_reg  <= g_pos_next;
            g_v_reg    <= f_v3_reg;
            g_done_reg <= f_done_reg;
        end
    end

    assign position_out = g_pos_reg;
    assign speed_out    = g_v_reg;
    assign plan_done    = g_done_reg;

endmodule

@@ rtl/core/trapezoid_profile_step.sv @@
// Top level of the trapezoid profile step: ports, configuration registers, pipeline.
//
// Advances one axis of an acceleration / coast / deceleration plan by one time step.
// Input stream (s_t*): one transfer carries step_time, position_in and speed_in.
// Output stream (m_t*): one transfer per input with position_out and speed_out in
// m_tdata and plan_done in m_tuser, in input order.
// Configuration channel (cfg_*): always ready; cfg_index selects plan_stopped,
// accel_time, accel_rate, coast_time, decel_time or decel_rate; other indexes are
// dropped. Write only while no item is in flight.
// m_tvalid rises once the item has passed through the seven register stages (three
// rows of multipliers, each followed by an add and clamp stage).
// Throughput is one item per cycle while m_tready stays high.
// Each stage advances on its own, so a stalled receiver first fills empty stages
// and input is refused only once all seven stages hold items; nothing is lost or
// repeated. Reset clears the stage valid bits and all configuration registers.
module trapezoid_profile_step (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [95:0]                   s_tdata,   // step_time, position_in, speed_in
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [63:0]                   m_tdata,   // position_out, speed_out
    output logic                          m_tuser,   // plan_done
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data
);

    tps_pkg::tps_cfg_t                  cfg_reg;
    logic [tps_pkg::PIPE_STAGES-1:0]    load;
    logic signed [31:0]                 position_out, speed_out;
    logic                               plan_done;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                tps_pkg::REG_PLAN_STOPPED: cfg_reg.plan_stopped <= cfg_data[0];
                tps_pkg::REG_ACCEL_TIME:   cfg_reg.accel_time   <= cfg_data;
                tps_pkg::REG_ACCEL_RATE:   cfg_reg.accel_rate   <= cfg_data;
                tps_pkg::REG_COAST_TIME:   cfg_reg.coast_time   <= cfg_data;
                tps_pkg::REG_DECEL_TIME:   cfg_reg.decel_time   <= cfg_data;
                tps_pkg::REG_DECEL_RATE:   cfg_reg.decel_rate   <= cfg_data;
                default:                   cfg_reg              <= cfg_reg;
            endcase
        end
    end

    // Stage handshake
    tps_flow_ctrl #(
        .STAGES (tps_pkg::PIPE_STAGES)
    ) u_flow (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .load      (load)
    );

    // Arithmetic
    tps_datapath u_datapath (
        .clk          (clk),
        .cfg          (cfg_reg),
        .load         (load),
        .step_time    (s_tdata[31:0]),
        .position_in  (s_tdata[63:32]),
        .speed_in     (s_tdata[95:64]),
        .position_out (position_out),
        .speed_out    (speed_out),
        .plan_done    (plan_done)
    );

    assign m_tdata = {speed_out, position_out};
    assign m_tuser = plan_done;

endmodule

@@ rtl/core/tps_checker.sv @@
// Port-level checks of the trapezoid profile step, bound to the top level.
module tps_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tuser
);

    // A stalled result holds until its transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Input is refused only when every stage is full and the output stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input refused with room in the pipeline");

    // With the receiver ready throughout, an accepted input yields a result once it has passed every stage
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready ##1 m_tready ##1 m_tready ##1 m_tready ##1 m_tready
        ##1 m_tready ##1 m_tready |=> m_tvalid)
        else $error("result missing after pipeline latency");

endmodule

bind trapezoid_profile_step tps_checker u_tps_checker (.*);

@@ tb/trapezoid_profile_step_tb.sv @@
// Self-checking testbench of the trapezoid profile step: stream driver, monitor and predictor.
module trapezoid_profile_step_tb;

    // Indexes past the register set; writes to them must be dropped
    localparam logic [tps_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [tps_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam logic [31:0] Q_ONE    = 32'h0001_0000;
    localparam logic [31:0] S32_MIN  = 32'h8000_0000;
    localparam logic [31:0] S32_MAX  = 32'h7fff_ffff;
    localparam logic [31:0] U32_MAX  = 32'hffff_ffff;
    localparam int          RANDOM_PHASES = 16;
    localparam int          MOVES_PER_PHASE = 117;

    // One input transfer and one output transfer
    typedef struct packed {
        logic [31:0]        step_time;
        logic signed [31:0] position;
        logic signed [31:0] speed;
    } move_t;

    typedef struct packed {
        logic signed [31:0] position;
        logic signed [31:0] speed;
        logic               done;
    } pose_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [95:0]                   s_tdata = '0;   // step_time, position_in, speed_in
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [63:0]                   m_tdata;        // position_out, speed_out
    logic                          m_tuser;        // plan_done
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [tps_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]                   cfg_data = '0;

    tps_pkg::tps_cfg_t plan_cfg = '0;
    move_t    moves_pending[$];
    pose_t    poses_due[$];
    int       moves_sent = 0;
    int       errors = 0;
    logic     steady = 1'b0;
    logic     rx_hold = 1'b0;

    trapezoid_profile_step u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #5 clk = ~clk;

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #3000000;
        $display("trapezoid_profile_step_tb failed");
        $finish;
    end

    // Clamp to the signed 32-bit range
    function automatic longint clamp32(input longint x);
        if (x > 64'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (x < -64'sd2147483648)
        begin
            return -64'sd2147483648;
        end
        return x;
    endfunction

    // Distance covered over a constant-rate phase, using the clamped mean speed
    function automatic longint ramp_travel(input longint vel, input longint rate,
                                           input longint span);
        longint prod;
        longint mean;
        prod = rate * span;
        mean = clamp32(vel + (prod >>> 17));
        return (mean * span) >>> 16;
    endfunction

    // Expected pose after one step of the plan
    function automatic pose_t advance_axis(input tps_pkg::tps_cfg_t c, input move_t m);
        logic [31:0] left;
        logic [31:0] used;
        longint      pos;
        longint      vel;
        longint      rate;
        longint      span;
        pose_t       r;
        left   = m.step_time;
        pos    = longint'(m.position);
        vel    = longint'(m.speed);
        r.done = c.plan_stopped;
        if (!c.plan_stopped && left != 0)
        begin
            // acceleration
            if (c.accel_time != 0)
            begin
                used = (left <= c.accel_time) ? left : c.accel_time;
                left = left - used;
                span = longint'(used);
                rate = longint'(c.accel_rate);
                pos  = pos + ramp_travel(vel, rate, span);
                vel  = clamp32(vel + ((rate * span) >>> 16));
            end
            if (left != 0)
            begin
                // coast
                if (c.coast_time != 0)
                begin
                    used = (left <= c.coast_time) ? left : c.coast_time;
                    left = left - used;
                    span = longint'(used);
                    pos  = pos + ((vel * span) >>> 16);
                end
                if (left != 0)
                begin
                    // deceleration
                    if (c.decel_time != 0)
                    begin
                        used = (left <= c.decel_time) ? left : c.decel_time;
                        left = left - used;
                        span = longint'(used);
                        rate = longint'(c.decel_rate);
                        pos  = pos + ramp_travel(vel, rate, span);
                        vel  = clamp32(vel + ((rate * span) >>> 16));
                    end
                    if (left != 0)
                    begin
                        r.done = 1'b1;
                    end
                end
            end
        end
        r.position = 32'(clamp32(pos));
        r.speed    = 32'(vel);
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        errors++;
        $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $time);
    endtask

    // Input driver: predict on each transfer, hold an unaccepted item, idle at random
    always @(posedge clk or negedge rst_n)
    begin : drive_moves
        logic taken;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            taken = s_tvalid && s_tready;
            if (taken)
            begin
                poses_due.push_back(advance_axis(plan_cfg, moves_pending[0]));
                void'(moves_pending.pop_front());
                moves_sent++;
            end
            if (s_tvalid && !taken)
            begin
                s_tvalid <= 1'b1;
            end
            else if (moves_pending.size() != 0 && (steady || $urandom_range(0, 99) >= 23))
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= {moves_pending[0].speed, moves_pending[0].position,
                             moves_pending[0].step_time};
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Output monitor: compare each transfer with the oldest expected pose
    always @(posedge clk or negedge rst_n)
    begin : watch_poses
        pose_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (poses_due.size() == 0)
                begin
                    flag_mismatch("unexpected result", m_tdata[31:0], '0);
                end
                else
                begin
                    want = poses_due.pop_front();
                    if (m_tdata[31:0] !== want.position)
                    begin
                        flag_mismatch("position_out", m_tdata[31:0], want.position);
                    end
                    if (m_tdata[63:32] !== want.speed)
                    begin
                        flag_mismatch("speed_out", m_tdata[63:32], want.speed);
                    end
                    if (m_tuser !== want.done)
                    begin
                        flag_mismatch("plan_done", {31'b0, m_tuser}, {31'b0, want.done});
                    end
                end
            end
            m_tready <= !rx_hold && (steady || $urandom_range(0, 99) >= 23);
        end
    end

    // Back-pressure: stall the receiver for a long stretch while input keeps coming
    initial
    begin
        @(posedge clk);
        while (!(moves_sent >= 500 && moves_pending.size() >= 60))
        begin
            @(posedge clk);
        end
        rx_hold <= 1'b1;
        repeat (150) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // Write one register and track it in the predictor copy
    task automatic write_plan_reg(input logic [tps_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [31:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        unique case (idx)
            tps_pkg::REG_PLAN_STOPPED: plan_cfg.plan_stopped = data[0];
            tps_pkg::REG_ACCEL_TIME:   plan_cfg.accel_time   = data;
            tps_pkg::REG_ACCEL_RATE:   plan_cfg.accel_rate   = data;
            tps_pkg::REG_COAST_TIME:   plan_cfg.coast_time   = data;
            tps_pkg::REG_DECEL_TIME:   plan_cfg.decel_time   = data;
            tps_pkg::REG_DECEL_RATE:   plan_cfg.decel_rate   = data;
            default:                   ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic load_plan(input logic halt, input logic [31:0] at, input logic [31:0] ar,
                             input logic [31:0] ct, input logic [31:0] dt,
                             input logic [31:0] dr);
        write_plan_reg(tps_pkg::REG_PLAN_STOPPED, {31'b0, halt});
        write_plan_reg(tps_pkg::REG_ACCEL_TIME, at);
        write_plan_reg(tps_pkg::REG_ACCEL_RATE, ar);
        write_plan_reg(tps_pkg::REG_COAST_TIME, ct);
        write_plan_reg(tps_pkg::REG_DECEL_TIME, dt);
        write_plan_reg(tps_pkg::REG_DECEL_RATE, dr);
    endtask

    task automatic queue_move(input logic [31:0] st, input logic [31:0] pos,
                              input logic [31:0] spd);
        move_t m;
        m.step_time = st;
        m.position  = pos;
        m.speed     = spd;
        moves_pending.push_back(m);
    endtask

    // Wait until every queued move has come back, then let the pipeline empty
    task automatic settle();
        @(negedge clk);
        while (moves_pending.size() != 0 || poses_due.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (12) @(negedge clk);
    endtask

    function automatic logic [31:0] pick_time();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return U32_MAX;
            2, 3:    return $urandom;
            default: return $urandom_range(1, 32'h0004_0000);
        endcase
    endfunction

    // Signed pick: extremes, full range or a small value around zero
    function automatic logic [31:0] pick_signed(input logic [31:0] spread);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return S32_MIN;
            2:       return S32_MAX;
            3, 4:    return $urandom;
            default: return $urandom_range(0, 2 * spread) - spread;
        endcase
    endfunction

    initial
    begin : stimulus
        logic [31:0] at;
        logic [31:0] ct;
        logic [31:0] dt;
        logic [31:0] st;
        int          n;
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end

        // Reset plan: every phase empty, so any nonzero step finishes it
        @(negedge clk);
        queue_move('0, S32_MAX, S32_MIN);
        queue_move(U32_MAX, S32_MIN, S32_MAX);
        queue_move(32'd1, '0, '0);
        settle();

        // Writes past the register set must leave the plan alone
        write_plan_reg(REG_SPARE_LO, U32_MAX);
        write_plan_reg(REG_SPARE_HI, U32_MAX);
        @(negedge clk);
        queue_move(Q_ONE, 32'h1234_5678, -Q_ONE);
        settle();

        // Stopped plan passes values through
        load_plan(1'b1, Q_ONE, 2 * Q_ONE, Q_ONE, Q_ONE, -2 * Q_ONE);
        @(negedge clk);
        queue_move(32'h0000_8000, S32_MIN, S32_MAX);
        queue_move('0, 32'h0003_0000, 32'h0001_8000);
        queue_move(U32_MAX, S32_MAX, S32_MIN);
        settle();

        // Nominal plan: land inside and on the edges of each phase
        write_plan_reg(tps_pkg::REG_PLAN_STOPPED, '0);
        @(negedge clk);
        queue_move(32'h0000_8000, '0, '0);
        queue_move(32'h0001_0000, '0, Q_ONE);
        queue_move(32'h0001_8000, -Q_ONE, '0);
        queue_move(32'h0002_0000, '0, '0);
        queue_move(32'h0002_8000, Q_ONE, -Q_ONE);
        queue_move(32'h0003_0000, '0, '0);
        queue_move(32'h0003_0001, '0, '0);
        queue_move('0, 32'h0000_7777, 32'h0000_4444);
        settle();

        // Extreme plan: drive velocity and position into saturation
        load_plan(1'b0, U32_MAX, S32_MAX, U32_MAX, U32_MAX, S32_MIN);
        @(negedge clk);
        queue_move(U32_MAX, S32_MAX, S32_MAX);
        queue_move(Q_ONE, S32_MIN, S32_MIN);
        queue_move(S32_MAX, '0, '0);
        settle();

        // No acceleration or deceleration: coast only
        load_plan(1'b0, '0, S32_MAX, 32'h0002_0000, '0, S32_MIN);
        @(negedge clk);
        queue_move(Q_ONE, '0, S32_MAX);
        queue_move(32'h0003_0000, S32_MAX, S32_MAX);
        queue_move(32'h0002_0000, S32_MIN, S32_MIN);
        settle();

        // Random plans, each followed by a batch of random moves
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            at = pick_time();
            ct = pick_time();
            dt = pick_time();
            load_plan($urandom_range(0, 7) == 0, at, pick_signed(32'h0008_0000), ct, dt,
                      pick_signed(32'h0008_0000));
            if ($urandom_range(0, 3) == 0)
            begin
                write_plan_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
            end
            @(negedge clk);
            steady = (phase == 2);
            for (n = 0; n < MOVES_PER_PHASE; n++)
            begin
                case ($urandom_range(0, 15))
                    0:       st = '0;
                    1:       st = U32_MAX;
                    2:       st = $urandom;
                    3:       st = at;
                    4:       st = at + ct;
                    5:       st = at + ct + dt;
                    6:       st = at + ct + dt + 32'd1;
                    default: st = $urandom_range(1, 32'h000c_0000);
                endcase
                queue_move(st, pick_signed(32'h0100_0000), pick_signed(32'h0010_0000));
            end
            settle();
            steady = 1'b0;
        end

        settle();
        if (poses_due.size() != 0)
        begin
            flag_mismatch("results missing", poses_due.size(), '0);
        end
        if (errors == 0)
        begin
            $display("trapezoid_profile_step_tb passed");
        end
        else
        begin
            $display("trapezoid_profile_step_tb failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/tps_pkg.sv
rtl/core/tps_flow_ctrl.sv
rtl/core/tps_datapath.sv
rtl/core/trapezoid_profile_step.sv
rtl/core/tps_checker.sv
tb/trapezoid_profile_step_tb.sv
